@@ rtl/pmtta_pkg.sv @@
// Shared constants for the power-management timer tick accounting core.
// Holds field widths, conversion factors and the register map; no dependencies.

package pmtta_pkg;

	// Default width of the free-running counter.
	localparam int PMTTA_COUNTER_BITS = 24;

	// Microseconds per counter cycle, scaled by 2^10.
	localparam logic [31:0] US_PER_CYCLE_NUM = 32'd286;
	localparam int          US_SHIFT         = 10;
	localparam logic [31:0] NS_PER_US        = 32'd1000;

	// Widths of the arithmetic values.
	localparam int US_W  = 32 - US_SHIFT;   // microseconds from one delta
	localparam int TL_W  = 20;              // tick length and remainder
	localparam int SUM_W = 23;              // microseconds plus remainder
	localparam int CNT_W = $clog2(SUM_W);   // divider step counter

	localparam logic [TL_W-1:0] TICK_LEN_RESET = TL_W'(1000);

	// Register map, by word index (byte address bit 2).
	localparam logic REG_TICK_LENGTH_US = 1'b0;

	// Request kinds.
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_READ = 1'b1;

endpackage

@@ rtl/pm_timer_tick_accounting_core.sv @@
// Tick accounting over a free-running power-management counter (uses pmtta_pkg).
// A bad sample goes from the check to the output register; a read item first passes
// two multiply steps and the add, and a tick item also the 23 divider steps and FIN.
// One item at a time; a new beat waits until the last result enters the output register.
// Reset (arst_n low, asynchronous) clears the sample, remainder and time base,
// arms the first-tick flag and loads a tick length of 1000 microseconds.

module pm_timer_tick_accounting_core
	import pmtta_pkg::*;
#(
	parameter int COUNTER_BITS = PMTTA_COUNTER_BITS
) (
	input  logic         clk,
	input  logic         arst_n,

	// Input beats.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // [31:0] raw_read_a, [63:32] raw_read_b, [95:64] raw_read_c
	input  logic         s_tuser,   // [0] req_type

	// Result beats.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // [22:0] offset_us, [86:23] monotonic_ns,
	                                // [109:87] extra_ticks, [111:110] zero
	output logic         m_tuser,   // [0] sample_bad

	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_US,
		ST_MUL_NS,
		ST_ADD,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t state_q;

	// Configuration register.
	logic [TL_W-1:0] tick_len_q;

	// Accounting state.
	logic [COUNTER_BITS-1:0] last_sample_q;
	logic [TL_W-1:0]         tick_rem_q;
	logic [63:0]             base_q;
	logic                    first_q;

	// Item under work.
	logic                    req_q;
	logic [31:0]             read_a_q;
	logic [31:0]             read_b_q;
	logic [31:0]             read_c_q;
	logic [COUNTER_BITS-1:0] delta_q;
	logic [US_W-1:0]         us_q;
	logic [31:0]             ns_q;
	logic [SUM_W-1:0]        sum_q;
	logic [63:0]             base_sum_q;

	// Divider registers.
	logic [SUM_W-1:0] div_dvd_q;
	logic [SUM_W-1:0] div_quo_q;
	logic [TL_W-1:0]  div_rem_q;
	logic [CNT_W-1:0] div_cnt_q;

	// Staged result waiting for the output register.
	logic             res_bad_q;
	logic [SUM_W-1:0] res_off_q;
	logic [63:0]      res_mono_q;
	logic [SUM_W-1:0] res_extra_q;

	// Output register.
	logic             m_tvalid_q;
	logic             m_bad_q;
	logic [SUM_W-1:0] m_off_q;
	logic [63:0]      m_mono_q;
	logic [SUM_W-1:0] m_extra_q;

	// Combinational helpers.
	logic             inconsistent;
	logic [31:0]      us_prod;
	logic [31:0]      ns_prod;
	logic [TL_W:0]    div_shifted;
	logic             div_ge;
	logic [TL_W:0]    div_diff;
	logic             cfg_write;
	logic [TL_W-1:0]  cfg_value;

	// The reads are inconsistent when any one of them sits strictly between
	// the other two in the wrong order.
	assign inconsistent = ((read_a_q > read_b_q) && (read_a_q < read_c_q)) ||
	                      ((read_b_q > read_c_q) && (read_b_q < read_a_q)) ||
	                      ((read_c_q > read_a_q) && (read_c_q < read_b_q));

	// Both products keep only their low 32 bits.
	assign us_prod = 32'(delta_q) * US_PER_CYCLE_NUM;
	assign ns_prod = 32'(us_q) * NS_PER_US;

	// One restoring step: shift in the next dividend bit, subtract when it fits.
	assign div_shifted = {div_rem_q, div_dvd_q[SUM_W-1]};
	assign div_ge      = div_shifted >= {1'b0, tick_len_q};
	assign div_diff    = div_shifted - {1'b0, tick_len_q};

	assign s_tready = (state_q == ST_IDLE);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_bad_q;
	assign m_tdata  = {2'b00, m_extra_q, m_mono_q, m_off_q};

	// Configuration port: every access completes in its access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready &&
	                   (paddr[2] == REG_TICK_LENGTH_US);
	assign cfg_value = (pwdata[TL_W-1:0] == '0) ? TL_W'(1) : pwdata[TL_W-1:0];
	assign prdata    = (paddr[2] == REG_TICK_LENGTH_US) ? 32'(tick_len_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_len_q <= TICK_LEN_RESET;
		end else if (cfg_write) begin
			tick_len_q <= cfg_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			last_sample_q <= '0;
			tick_rem_q    <= '0;
			base_q        <= '0;
			first_q       <= 1'b1;
			req_q         <= REQ_TICK;
			read_a_q      <= '0;
			read_b_q      <= '0;
			read_c_q      <= '0;
			delta_q       <= '0;
			us_q          <= '0;
			ns_q          <= '0;
			sum_q         <= '0;
			base_sum_q    <= '0;
			div_dvd_q     <= '0;
			div_quo_q     <= '0;
			div_rem_q     <= '0;
			div_cnt_q     <= '0;
			res_bad_q     <= 1'b0;
			res_off_q     <= '0;
			res_mono_q    <= '0;
			res_extra_q   <= '0;
			m_tvalid_q    <= 1'b0;
			m_bad_q       <= 1'b0;
			m_off_q       <= '0;
			m_mono_q      <= '0;
			m_extra_q     <= '0;
		end else begin
			// In ST_OUT an accepted beat is replaced by the next one below.
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						req_q    <= s_tuser;
						read_a_q <= s_tdata[31:0];
						read_b_q <= s_tdata[63:32];
						read_c_q <= s_tdata[95:64];
						state_q  <= ST_CHECK;
					end
				end

				ST_CHECK: begin
					// The wrapped delta is taken in counter width.
					delta_q <= read_b_q[COUNTER_BITS-1:0] - last_sample_q;
					if (inconsistent) begin
						res_bad_q   <= 1'b1;
						res_off_q   <= '0;
						res_mono_q  <= '0;
						res_extra_q <= '0;
						state_q     <= ST_OUT;
					end else begin
						state_q <= ST_MUL_US;
					end
				end

				ST_MUL_US: begin
					us_q    <= us_prod[31:US_SHIFT];
					state_q <= ST_MUL_NS;
				end

				ST_MUL_NS: begin
					ns_q    <= ns_prod;
					sum_q   <= SUM_W'(tick_rem_q) + SUM_W'(us_q);
					state_q <= ST_ADD;
				end

				ST_ADD: begin
					base_sum_q <= base_q + 64'(ns_q);
					if (req_q == REQ_READ) begin
						res_bad_q   <= 1'b0;
						res_off_q   <= sum_q;
						res_mono_q  <= base_q + 64'(ns_q);
						res_extra_q <= '0;
						state_q     <= ST_OUT;
					end else begin
						div_dvd_q <= sum_q;
						div_quo_q <= '0;
						div_rem_q <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end

				ST_DIV: begin
					div_dvd_q <= {div_dvd_q[SUM_W-2:0], 1'b0};
					div_quo_q <= {div_quo_q[SUM_W-2:0], div_ge};
					div_rem_q <= div_ge ? div_diff[TL_W-1:0] : div_shifted[TL_W-1:0];
					div_cnt_q <= div_cnt_q + CNT_W'(1);
					if (div_cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= ST_FIN;
					end
				end

				ST_FIN: begin
					// The remainder is dropped on the first tick and when less
					// than one whole tick has passed.
					last_sample_q <= read_b_q[COUNTER_BITS-1:0];
					base_q        <= base_sum_q;
					first_q       <= 1'b0;
					res_bad_q     <= 1'b0;
					res_mono_q    <= base_sum_q;
					res_extra_q   <= (div_quo_q >= SUM_W'(2)) ? div_quo_q - SUM_W'(1) : '0;
					if (first_q || (div_quo_q == '0)) begin
						tick_rem_q <= '0;
						res_off_q  <= '0;
					end else begin
						tick_rem_q <= div_rem_q;
						res_off_q  <= SUM_W'(div_rem_q);
					end
					state_q <= ST_OUT;
				end

				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_bad_q    <= res_bad_q;
						m_off_q    <= res_off_q;
						m_mono_q   <= res_mono_q;
						m_extra_q  <= res_extra_q;
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/tick_accounting_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the tick accounting core. It follows the input, result and
// configuration channels, predicts each result beat and compares it field by field.
// Depends on pmtta_pkg for the counter width, conversion factors and register map.

module tick_accounting_checker
	import pmtta_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [95:0]  s_tdata,   // [31:0] raw_read_a, [63:32] raw_read_b, [95:64] raw_read_c
	input  logic         s_tuser,   // [0] req_type
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,   // [22:0] offset_us, [86:23] monotonic_ns,
	                                // [109:87] extra_ticks, [111:110] zero
	input  logic         m_tuser,   // [0] sample_bad
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic [31:0]  prdata,
	input  logic         pready,
	output int           fail_count,
	output int           pending
);

	localparam logic [31:0] CTR_MASK = 32'((33'd1 << PMTTA_COUNTER_BITS) - 33'd1);
	localparam logic [31:0] TL_MASK  = 32'((33'd1 << TL_W) - 33'd1);

	typedef struct packed {
		logic        bad;
		logic [22:0] offset_us;
		logic [63:0] mono_ns;
		logic [22:0] extra_ticks;
	} acct_result_t;

	logic [31:0]  tick_len_us;
	logic [31:0]  prev_sample;
	logic [31:0]  carry_us;
	logic [63:0]  base_ns;
	logic         first_tick;
	acct_result_t expected_results[$];

	// Works out the result of one input beat and advances the accounting state.
	function automatic acct_result_t account_item(input logic req,
			input logic [31:0] ra, input logic [31:0] rb, input logic [31:0] rc);
		acct_result_t r;
		logic [31:0]  sample, delta, prod, us, ns32, sum, lost, rem;
		r = '0;
		// One read strictly between the other two, out of order, means a torn read.
		if ((ra > rb && ra < rc) || (rb > rc && rb < ra) || (rc > ra && rc < rb)) begin
			r.bad = 1'b1;
			return r;
		end
		sample = rb & CTR_MASK;
		delta  = (sample - prev_sample) & CTR_MASK;
		prod   = delta * US_PER_CYCLE_NUM;
		us     = prod >> US_SHIFT;
		ns32   = us * NS_PER_US;
		if (req == REQ_TICK) begin
			base_ns     = base_ns + {32'd0, ns32};
			prev_sample = sample;
			sum         = us + carry_us;
			lost        = sum / tick_len_us;
			rem         = sum % tick_len_us;
			if (first_tick || lost == 32'd0) begin
				rem        = 32'd0;
				first_tick = 1'b0;
			end
			carry_us      = rem;
			lost          = (lost >= 32'd2) ? lost - 32'd1 : 32'd0;
			r.offset_us   = rem[22:0];
			r.mono_ns     = base_ns;
			r.extra_ticks = lost[22:0];
		end else begin
			sum         = carry_us + us;
			r.offset_us = sum[22:0];
			r.mono_ns   = base_ns + {32'd0, ns32};
		end
		return r;
	endfunction

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		acct_result_t want, got;
		if (!arst_n) begin
			tick_len_us = 32'(TICK_LEN_RESET);
			prev_sample = '0;
			carry_us    = '0;
			base_ns     = '0;
			first_tick  = 1'b1;
			fail_count  = 0;
			expected_results.delete();
		end else begin
			if (psel && penable && pready && paddr[2] == REG_TICK_LENGTH_US) begin
				if (pwrite) begin
					tick_len_us = pwdata & TL_MASK;
					if (tick_len_us == 32'd0)
						tick_len_us = 32'd1;
				end else begin
					check_field("tick_length_us readback", {32'd0, tick_len_us}, {32'd0, prdata});
				end
			end
			// Results leave before new beats are booked, so a beat taken at this
			// edge can never be matched against its own result.
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[22:0], m_tdata[86:23], m_tdata[109:87]};
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with none expected, expected nothing, got 0x%0h",
						$time, got);
				end else begin
					want = expected_results.pop_front();
					check_field("sample_bad", 64'(want.bad), 64'(got.bad));
					check_field("offset_us", 64'(want.offset_us), 64'(got.offset_us));
					check_field("monotonic_ns", want.mono_ns, got.mono_ns);
					check_field("extra_ticks", 64'(want.extra_ticks), 64'(got.extra_ticks));
				end
				check_field("m_tdata padding", 64'd0, 64'(m_tdata[111:110]));
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(account_item(s_tuser, s_tdata[31:0],
					s_tdata[63:32], s_tdata[95:64]));
		end
		pending <= expected_results.size();
	end

endmodule

@@ tb/tb_pm_timer_tick_accounting_core.sv @@
`timescale 1ns / 1ps
// Top of the tick accounting testbench: clock, reset, input and configuration
// stimulus, result back-pressure and the verdict. Depends on pmtta_pkg, the core
// and tick_accounting_checker, which predicts and compares every result beat.

module tb_pm_timer_tick_accounting_core;
	import pmtta_pkg::*;

	localparam logic [31:0] CTR_MASK         = 32'((33'd1 << PMTTA_COUNTER_BITS) - 33'd1);
	localparam int          LONG_HOLD_CYCLES = 400;
	localparam int          DRAIN_CYCLES     = 60;
	localparam int          NUM_PHASES       = 6;
	localparam int          ITEMS_PER_PHASE  = 280;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [95:0]  s_tdata  = '0;   // [31:0] raw_read_a, [63:32] raw_read_b, [95:64] raw_read_c
	logic         s_tuser  = 1'b0; // [0] req_type
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;         // [22:0] offset_us, [86:23] monotonic_ns,
	                               // [109:87] extra_ticks, [111:110] zero
	logic         m_tuser;         // [0] sample_bad
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [2:0]   paddr    = '0;
	logic [31:0]  pwdata   = '0;
	logic [31:0]  prdata;
	logic         pready;

	int fail_count;
	int pending;

	// Idle rates in percent of cycles, changed per phase by the stimulus process.
	int sender_idle_pct = 0;
	int recv_idle_pct   = 0;
	// Each increment asks the receiver process for one long hold-off.
	int long_hold_asks  = 0;
	// Tick length in effect, used only to shape well-formed counter steps.
	int tick_len_cur    = 1000;
	// Free-running counter that the well-formed reads are taken from.
	logic [31:0] pm_count = '0;

	always #5 clk = ~clk;

	pm_timer_tick_accounting_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	tick_accounting_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Offers one beat, idling the sender first at the current rate, and returns at
	// the rising edge that takes it. The valid stays high so that a following beat
	// goes out back to back; drain() lowers it when the stream pauses.
	task automatic send_item(input logic req, input logic [31:0] ra, input logic [31:0] rb,
			input logic [31:0] rc);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {rc, rb, ra};
		s_tuser  <= req;
		do @(posedge clk); while (!s_tready);
	endtask

	// Three identical reads are always consistent and make the sample exact.
	task automatic send_same(input logic req, input logic [31:0] value);
		send_item(req, value, value, value);
	endtask

	// Stops offering beats and waits until every predicted result has come back,
	// so the core is idle and the tick length may change.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	// One configuration transfer: a setup cycle, then the access cycle until pready.
	task automatic apb_access(input logic wr, input logic [31:0] wdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_TICK_LENGTH_US, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Writes the tick length and reads it back; the checker compares the readback.
	task automatic program_tick_length(input logic [31:0] value);
		apb_access(1'b1, value);
		apb_access(1'b0, 32'd0);
		tick_len_cur = (value[TL_W-1:0] == '0) ? 1 : int'(value[TL_W-1:0]);
	endtask

	// Result back-pressure. Besides the random idling it can hold tready low for a
	// long stretch, counted here, while the sender keeps offering beats; with one
	// item in work and one result waiting, the core then has to stall its input.
	initial begin : result_ready_gen
		int hold_left;
		int holds_seen;
		hold_left  = 0;
		holds_seen = 0;
		forever begin
			@(negedge clk);
			if (holds_seen != long_hold_asks) begin
				holds_seen = long_hold_asks;
				hold_left  = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		logic [31:0]     ra, rb, rc, v0, v1, v2, hi, step, new_len;
		longint unsigned span;
		int unsigned     pick;
		logic            req;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 23;
		recv_idle_pct   = 62;

		// The tick length must read back as its reset value before any write.
		apb_access(1'b0, 32'd0);

		// Directed beats at the reset tick length of 1000 microseconds.
		send_same(REQ_READ, 32'h0000_0000);                        // fresh state
		send_item(REQ_TICK, 32'd1, 32'd3, 32'd2);                  // third read torn
		send_item(REQ_READ, 32'd2, 32'd1, 32'd3);                  // first read torn
		send_item(REQ_TICK, 32'd3, 32'd2, 32'd1);                  // middle read torn
		send_same(REQ_READ, 32'hFFFF_FFFF);                        // widest delta on a read
		send_same(REQ_TICK, 32'h0012_3456);                        // first tick clears remainder
		send_same(REQ_TICK, 32'h0012_3456);                        // zero delta, under one tick
		send_same(REQ_TICK, 32'h0012_5456);                        // two ticks lost, remainder kept
		send_same(REQ_READ, 32'h0012_5800);                        // offset includes the remainder
		send_same(REQ_TICK, 32'h0012_5455);                        // full-range delta, product wraps
		send_item(REQ_TICK, 32'hFFFF_FFF0, 32'h0000_0010, 32'h0000_0020); // counter rollover
		send_item(REQ_READ, 32'hAB00_0100, 32'hAB00_0200, 32'hAB00_0300); // upper bits set
		send_item(REQ_TICK, 32'd5, 32'd5, 32'd3);                  // ties count as consistent
		send_same(REQ_TICK, 32'h0000_0000);
		drain();

		// A zero tick length is stored as one, which makes the lost count huge.
		program_tick_length(32'd0);
		send_same(REQ_TICK, 32'h00FF_FFFF);
		send_same(REQ_READ, 32'h0080_0000);
		send_same(REQ_TICK, 32'h0000_1000);
		drain();

		// Upper bits of the write are dropped; the longest tick length results.
		program_tick_length(32'hFFFF_FFFF);
		send_same(REQ_TICK, 32'h00FF_FFFE);
		send_same(REQ_READ, 32'h0040_0000);
		send_same(REQ_TICK, 32'h0070_0000);

		// Random phases. Most beats are well-formed counter reads that advance by
		// whole ticks plus jitter, so lost-tick compensation and remainders get
		// exercised; the rest are torn reads and plain noise.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			case (ph)
				0:       new_len = 32'd1000;
				1:       new_len = 32'd1000000;
				2:       new_len = 32'd0;
				3:       new_len = 32'hFFFF_FFFF;
				4:       new_len = $urandom_range(5000, 2);
				default: new_len = $urandom_range(1000000, 1);
			endcase
			program_tick_length(new_len);
			// Sender light and receiver heavy idling first, then the reverse, then none.
			sender_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 62 : 0;
			recv_idle_pct   = (ph < 2) ? 62 : (ph < 4) ? 23 : 0;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ((ph == 1 || ph == 4) && n == 100)
					long_hold_asks++;
				pick = $urandom_range(99);
				req  = 1'($urandom_range(1));
				if (pick < 12) begin
					send_item(req, $urandom, $urandom, $urandom);
				end else if (pick < 18) begin
					// Three distinct values put out of order so that one read is torn.
					v0 = $urandom & 32'h7FFF_FFFF;
					v1 = v0 + 32'd1 + $urandom_range(1000);
					v2 = v1 + 32'd1 + $urandom_range(1000);
					case ($urandom_range(2))
						0:       send_item(req, v0, v2, v1);
						1:       send_item(req, v1, v0, v2);
						default: send_item(req, v2, v1, v0);
					endcase
				end else begin
					if ($urandom_range(19) == 0) begin
						step = $urandom & CTR_MASK;
					end else begin
						// Roughly 1024/286 counter cycles per microsecond.
						span = 64'($urandom_range(4));
						span = span * tick_len_cur * 1024 / 286 + $urandom_range(4000);
						step = span[31:0] & CTR_MASK;
					end
					pm_count = (pm_count + step) & CTR_MASK;
					hi = ($urandom_range(9) == 0) ? ($urandom & ~CTR_MASK) : 32'd0;
					ra = pm_count | hi;
					rb = ((pm_count + $urandom_range(3)) & CTR_MASK) | hi;
					rc = (((rb & CTR_MASK) + $urandom_range(3)) & CTR_MASK) | hi;
					pm_count = rb & CTR_MASK;
					send_item(($urandom_range(99) < 35) ? REQ_READ : REQ_TICK, ra, rb, rc);
				end
			end
		end

		// Every beat has been taken; wait for the last results, then wait on for any
		// stray beat before the verdict.
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// A hung handshake ends the run here, far beyond the slowest correct run.
	initial begin : watchdog
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
